>>> sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

   // Fixed field widths
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned AddrWidth    = 32;
   localparam int unsigned LenWidth     = 5;
   localparam int unsigned PatternBytes = 16;
   localparam int unsigned PatIdxWidth  = 4;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CareWidth    = 16;

   // Register indexes of the configuration port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_CARE_MASK      = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // Per-transaction control that every cell sees
   typedef struct packed {
      logic accept;
   } cell_ctl_type;

   // Compare setup for one cell, derived from the configuration
   typedef struct packed {
      logic [ByteWidth-1:0] pat_byte;
      logic                 care;
      logic                 in_use;
   } cell_cmp_type;

endpackage

>>> sv/mbps_cell.sv
// One window cell: holds a byte and its in-region flag and compares the incoming byte.
module mbps_cell
   import mbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  cell_cmp_type         cmp,
   input  logic [ByteWidth-1:0] byte_in,
   input  logic                 valid_in,
   output logic [ByteWidth-1:0] byte_ff,
   output logic                 valid_ff,
   output logic                 hit
);

   logic [ByteWidth-1:0] byte_in_d;
   logic                 valid_in_d;

   // Shift in the neighbor's byte on every accepted transaction
   always_comb begin
      byte_in_d  = ctl.accept ? byte_in : byte_ff;
      valid_in_d = ctl.accept ? valid_in : valid_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
   end

   // Compare the value this cell takes on with its pattern byte
   assign hit = !cmp.in_use || (valid_in && (!cmp.care || (byte_in == cmp.pat_byte)));

endmodule

>>> sv/masked_byte_pattern_search.sv
// Masked byte pattern search: the top level with config registers, cell chain and output skid.
//
// Scans a byte stream one byte per clock cycle. Each accepted transaction shifts
// its byte into a row of MAX_PATTERN cells; every cell compares the byte it takes
// against the pattern byte lined up with it, so the whole masked window compare is
// done as the byte enters; the match address is registered into the output register,
// or into the skid entry while the output is held. A new byte is taken every cycle as
// long as the result path is not backed up: an output register plus one skid entry
// decouple the two sides, and req_tready drops only while the skid entry is occupied.
// A transaction with req_tuser set starts a new region: the window and offset restart
// and the region base is taken from the same transaction. The user must write the
// configuration through the csr_ port only while no transaction is in flight; the block
// does not enforce this. pattern_length of zero or above MAX_PATTERN disables matching.
module masked_byte_pattern_search
   import mbps_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration write port
   input  logic                    csr_wen,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   // input byte stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [39:0]             req_tdata,  // [7:0] data_byte, [39:8] region_base
   input  logic                    req_tuser,  // [0] region_first
   // match results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata   // [31:0] match_address
);

   logic [CsrDataWidth-1:0] pattern_low_ff;
   logic [CsrDataWidth-1:0] pattern_high_ff;
   logic [CareWidth-1:0]    care_mask_ff;
   logic [LenWidth-1:0]     pattern_length_ff;

   logic [AddrWidth-1:0]    offset_ff;
   logic [AddrWidth-1:0]    offset_in;
   logic [AddrWidth-1:0]    base_ff;
   logic [AddrWidth-1:0]    base_in;
   logic [AddrWidth-1:0]    offset_start;

   logic                    accept;
   logic                    region_first;
   logic [ByteWidth-1:0]    data_byte;
   logic [AddrWidth-1:0]    region_base;
   logic                    len_ok;
   logic                    match_hit;
   logic [AddrWidth-1:0]    match_address;
   logic                    new_valid;

   logic [2*CsrDataWidth-1:0] pattern_all;
   cell_ctl_type              ctl;

   logic [ByteWidth-1:0] cell_byte  [MAX_PATTERN];
   logic                 cell_valid [MAX_PATTERN];
   logic [ByteWidth-1:0] chain_byte [MAX_PATTERN];
   logic                 chain_valid[MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_hit;

   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   logic [AddrWidth-1:0] rsp_tdata_ff;
   logic [AddrWidth-1:0] rsp_tdata_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [AddrWidth-1:0] skid_data_ff;
   logic [AddrWidth-1:0] skid_data_in;
   logic                 out_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_CARE_MASK:      care_mask_ff      <= csr_wdata[CareWidth-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input unpacking
   assign accept       = req_tvalid && req_tready;
   assign data_byte    = req_tdata[ByteWidth-1:0];
   assign region_base  = req_tdata[ByteWidth +: AddrWidth];
   assign region_first = req_tuser;
   assign ctl.accept   = accept;
   assign pattern_all  = {pattern_high_ff, pattern_low_ff};

   // Region offset (saturating) and base
   always_comb begin
      offset_start = region_first ? '0 : offset_ff;
      offset_in    = (offset_start == '1) ? offset_start : offset_start + 1'b1;
      base_in      = region_first ? region_base : base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         base_ff   <= '0;
      end else if (accept) begin
         offset_ff <= offset_in;
         base_ff   <= base_in;
      end
   end

   // Cell chain: cell 0 takes the new byte, cell d takes cell d-1; a region start clears
   // the in-region flags behind the head
   for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cell
      cell_cmp_type            cmp;
      logic [LenWidth-1:0]     pat_idx;

      assign pat_idx     = pattern_length_ff - 1'b1 - LenWidth'(d);
      assign cmp.in_use  = len_ok && (LenWidth'(d) < pattern_length_ff);
      assign cmp.pat_byte = pattern_all[pat_idx[PatIdxWidth-1:0]*ByteWidth +: ByteWidth];
      assign cmp.care    = care_mask_ff[pat_idx[PatIdxWidth-1:0]];

      if (d == 0) begin : g_head
         assign chain_byte[d]  = data_byte;
         assign chain_valid[d] = 1'b1;
      end else begin : g_body
         assign chain_byte[d]  = cell_byte[d-1];
         assign chain_valid[d] = cell_valid[d-1] && !region_first;
      end

      mbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cmp      (cmp),
         .byte_in  (chain_byte[d]),
         .valid_in (chain_valid[d]),
         .byte_ff  (cell_byte[d]),
         .valid_ff (cell_valid[d]),
         .hit      (cell_hit[d])
      );
   end

   // Match decision and address of the first matched byte
   assign len_ok        = (pattern_length_ff != '0) &&
                          (pattern_length_ff <= LenWidth'(MAX_PATTERN));
   assign match_hit     = len_ok && (&cell_hit);
   assign match_address = base_in + (offset_in - {{(AddrWidth-LenWidth){1'b0}},
                                                  pattern_length_ff});
   assign new_valid     = accept && match_hit;

   // Output register with one skid entry
   assign req_tready = !skid_valid_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_tvalid_in = 1'b1;
            rsp_tdata_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_tvalid_in = new_valid;
            rsp_tdata_in  = match_address;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = match_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   // A skid entry only exists behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid entry valid with empty output register");

   // A region start restarts the offset at one
   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && region_first) |=> (offset_ff == 32'd1))
      else $error("region offset not restarted");

   // The newest cell always holds an in-region byte after a transaction
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> cell_valid[0])
      else $error("head cell not valid after accept");

   // A zero pattern length never produces a result
   a_len_zero_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && (pattern_length_ff == '0) && !rsp_tvalid_ff) |=> !rsp_tvalid_ff)
      else $error("result produced with zero pattern length");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the masked byte pattern search block.
`timescale 1ns / 100ps

module tb_top;
   import mbps_pkg::*;

   localparam int unsigned CycleLimit   = 1000000;
   localparam int unsigned SettleCycles = 4;
   localparam int unsigned RandomBytes  = 2000;
   localparam int unsigned MaxPhases    = 30;

   // Directed stimulus table
   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_BYTE
   } row_kind_type;

   typedef enum logic [1:0] {
      EXP_PREDICT,
      EXP_NONE,
      EXP_ADDR
   } exp_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      csr_index_type        idx;
      logic [63:0]          value;
      logic [ByteWidth-1:0] data;
      logic                 first;
      logic [AddrWidth-1:0] base;
      exp_kind_type         exp;
      logic [AddrWidth-1:0] addr;
   } step_row_type;

   localparam int unsigned DirectedRows = 32;
   localparam step_row_type DIRECTED [DirectedRows] = '{
      // length zero after reset, no region start yet
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h00, 1'b0, 32'h0000_0000, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'hFF, 1'b0, 32'hFFFF_FFFF, EXP_NONE, 32'h0},
      // one wildcard byte: every byte matches, base still zero
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_CSR,  CSR_CARE_MASK,      64'h0, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h5A, 1'b0, 32'h0000_0000, EXP_ADDR, 32'h2},
      // region at the top of the address space, then wrap
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'hFF, 1'b1, 32'hFFFF_FFFF, EXP_ADDR,
        32'hFFFF_FFFF},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h00, 1'b0, 32'h0000_0000, EXP_ADDR, 32'h0},
      // full 16 byte pattern, every byte cared
      '{ROW_CSR,  CSR_PATTERN_LOW,    64'h0706_0504_0302_0100, 8'h00, 1'b0, 32'h0,
        EXP_NONE, 32'h0},
      '{ROW_CSR,  CSR_PATTERN_HIGH,   64'h0F0E_0D0C_0B0A_0908, 8'h00, 1'b0, 32'h0,
        EXP_NONE, 32'h0},
      '{ROW_CSR,  CSR_CARE_MASK,      64'hFFFF, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'd16, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h00, 1'b1, 32'h0000_1000, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h01, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h02, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h03, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h04, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h05, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h06, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h07, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h08, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h09, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0A, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0B, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0C, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0D, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0E, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h0F, 1'b0, 32'h0, EXP_ADDR, 32'h0000_1000},
      // new region restarts the window
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'hFF, 1'b1, 32'h8000_0000, EXP_PREDICT, 32'h0},
      // lengths above the window disable matching
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'd17, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'hAA, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 32'h0, EXP_NONE, 32'h0},
      '{ROW_BYTE, CSR_PATTERN_LOW,    64'h0, 8'h55, 1'b0, 32'h0, EXP_NONE, 32'h0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wen = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [39:0]             req_tdata = '0;  // [7:0] data_byte, [39:8] region_base
   logic                    req_tuser = 1'b0; // [0] region_first
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [31:0]             rsp_tdata;        // [31:0] match_address

   // Scanner image: configuration and state
   logic [63:0]          pat_lo = '0;
   logic [63:0]          pat_hi = '0;
   logic [CareWidth-1:0] care_bits = '0;
   logic [LenWidth-1:0]  pat_len = '0;
   logic [ByteWidth-1:0] win [PatternBytes];
   logic [AddrWidth-1:0] offs = '0;
   logic [AddrWidth-1:0] cur_base = '0;

   logic [AddrWidth-1:0] expected_addrs [$];
   int unsigned          errors = 0;
   int unsigned          bytes_sent = 0;
   int unsigned          cycles = 0;
   bit                   calm = 1'b0;

   masked_byte_pattern_search #(
      .MAX_PATTERN(PatternBytes)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [ByteWidth-1:0] pattern_at(input int unsigned j);
      logic [127:0] bits;
      bits = {pat_hi, pat_lo};
      return bits[8*j +: 8];
   endfunction

   // Mostly no gap, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Append one expected match address at the tail of the queue
   function automatic void expect_match(input logic [AddrWidth-1:0] a);
      expected_addrs.insert(expected_addrs.size(), a);
   endfunction

   // Shift one byte into the window and work out the match address, if any
   function automatic void scan_byte(input logic [ByteWidth-1:0] b, input logic first,
                                     input logic [AddrWidth-1:0] base,
                                     output logic hit, output logic [AddrWidth-1:0] addr);
      int unsigned n;
      int unsigned i;
      n = pat_len;
      hit = 1'b0;
      addr = '0;
      if (first) begin
         for (i = 0; i < PatternBytes; i++) win[i] = '0;
         offs = '0;
         cur_base = base;
      end
      for (i = 0; i + 1 < PatternBytes; i++) win[i] = win[i+1];
      win[PatternBytes-1] = b;
      if (offs != 32'hFFFF_FFFF) offs = offs + 1;
      if (n == 0 || n > PatternBytes || offs < n) return;
      hit = 1'b1;
      for (i = 0; i < n; i++) begin
         if (care_bits[i] && win[PatternBytes-n+i] != pattern_at(i)) hit = 1'b0;
      end
      if (hit) addr = cur_base + (offs - n);
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_PATTERN_LOW:    pat_lo = value;
         CSR_PATTERN_HIGH:   pat_hi = value;
         CSR_CARE_MASK:      care_bits = value[CareWidth-1:0];
         CSR_PATTERN_LENGTH: pat_len = value[LenWidth-1:0];
         default: ;
      endcase
   endtask

   // Stop sending and wait for every outstanding match, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Send one byte transaction and record what it should produce
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic first,
                            input logic [AddrWidth-1:0] base, input exp_kind_type exp,
                            input logic [AddrWidth-1:0] typed_addr);
      int unsigned gap;
      logic hit;
      logic [AddrWidth-1:0] addr;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {base, b};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      scan_byte(b, first, base, hit, addr);
      case (exp)
         EXP_ADDR:    expect_match(typed_addr);
         EXP_PREDICT: if (hit) expect_match(addr);
         default: ;
      endcase
   endtask

   // One random configuration followed by regions with planted patterns
   task automatic run_random_phase();
      int unsigned n_items, k, r, region_left, plant_left, plen, j;
      logic [ByteWidth-1:0] b;
      logic first;
      logic [AddrWidth-1:0] base;
      drain();
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
         csr_write(CSR_PATTERN_LOW, '1);
         csr_write(CSR_PATTERN_HIGH, '1);
      end else if (r == 1) begin
         csr_write(CSR_PATTERN_LOW, '0);
         csr_write(CSR_PATTERN_HIGH, '0);
      end else begin
         csr_write(CSR_PATTERN_LOW, {$urandom, $urandom});
         csr_write(CSR_PATTERN_HIGH, {$urandom, $urandom});
      end
      r = $urandom_range(0, 9);
      csr_write(CSR_CARE_MASK, (r < 2) ? 64'hFFFF : (r == 2) ? 64'h0 :
                               64'($urandom_range(0, 65535)));
      r = $urandom_range(0, 9);
      if (r == 0) csr_write(CSR_PATTERN_LENGTH, 64'd0);
      else if (r == 1) csr_write(CSR_PATTERN_LENGTH, 64'($urandom_range(17, 31)));
      else if (r == 2) csr_write(CSR_PATTERN_LENGTH, ($urandom_range(0, 1) != 0) ? 64'd16 : 64'd1);
      else csr_write(CSR_PATTERN_LENGTH, 64'($urandom_range(1, 16)));
      plen = (pat_len >= 1 && pat_len <= PatternBytes) ? pat_len : $urandom_range(1, 16);
      n_items = $urandom_range(80, 200);
      region_left = 0;
      plant_left = 0;
      for (k = 0; k < n_items; k++) begin
         first = (region_left == 0) || ($urandom_range(0, 99) == 0);
         base = {$urandom};
         if (first) begin
            r = $urandom_range(0, 19);
            region_left = (r < 3) ? $urandom_range(1, 3) :
                          (r == 3) ? $urandom_range(100, 250) : $urandom_range(4, 40);
            r = $urandom_range(0, 19);
            if (r < 2) base = 32'hFFFF_FFFF - $urandom_range(0, 20);
            else if (r == 2) base = '0;
            plant_left = 0;
         end
         if (plant_left == 0 && $urandom_range(0, 5) == 0) plant_left = plen;
         if (plant_left != 0) begin
            j = plen - plant_left;
            b = care_bits[j] ? pattern_at(j) : 8'($urandom);
            plant_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            b = pattern_at($urandom_range(0, PatternBytes - 1));
         end else begin
            b = 8'($urandom);
         end
         region_left--;
         send_byte(b, first, base, EXP_PREDICT, '0);
         // occasional hold-off until every match is out
         if ($urandom_range(0, 149) == 0) drain();
      end
   endtask

   // Result side backpressure
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm) stall_left = pick_gap();
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_addrs.size() == 0) begin
            $display("%0t: match_address expected none, got %h", $time, rsp_tdata);
            errors <= errors + 1;
         end else begin
            if (rsp_tdata !== expected_addrs[0]) begin
               $display("%0t: match_address expected %h, got %h",
                        $time, expected_addrs[0], rsp_tdata);
               errors <= errors + 1;
            end
            void'(expected_addrs.pop_front());
         end
      end
   end

   // Main sequence
   initial begin
      int unsigned row;
      int unsigned phase;
      for (row = 0; row < PatternBytes; row++) win[row] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DirectedRows; row++) begin
         if (DIRECTED[row].kind == ROW_CSR) begin
            drain();
            csr_write(DIRECTED[row].idx, DIRECTED[row].value);
         end else begin
            send_byte(DIRECTED[row].data, DIRECTED[row].first, DIRECTED[row].base,
                      DIRECTED[row].exp, DIRECTED[row].addr);
         end
      end

      phase = 0;
      bytes_sent = 0;
      while (bytes_sent < RandomBytes && phase < MaxPhases) begin
         run_random_phase();
         phase++;
      end

      drain();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
